[rtl/variable_coeff_laplacian_assembly_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the variable coefficient Laplacian assembly
// Shared helpers that wrap a clocked implication with reset disable.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_COEFF_LAPLACIAN_ASSEMBLY_DEFINES_SVH
`define VARIABLE_COEFF_LAPLACIAN_ASSEMBLY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VCLA_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VCLA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vcla_pkg.sv]
// ----------------------------------------------------------------------------
// vcla_pkg
// Types, widths and constants shared by the Laplacian assembly modules.
// ----------------------------------------------------------------------------
package vcla_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + 1;
  localparam int INV_W      = 24;
  localparam int WT_W       = SUM_W + INV_W;
  localparam int PAIR_W     = WT_W + 1;
  localparam int DIAG_W     = WT_W + 2;
  localparam int VAL_W      = 48;
  localparam int ID_W       = 12;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 2 * ID_W + VAL_W;
  localparam int M_USER_W   = 1;

  localparam logic [DIM_W-1:0] CFG_COLS_RST = 7'd64;
  localparam logic [DIM_W-1:0] CFG_ROWS_RST = 7'd64;
  localparam logic [INV_W-1:0] CFG_INV_RST  = 24'd1081600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS   = 2'd0,
    REG_ROWS   = 2'd1,
    REG_INV_H2 = 2'd2
  } vcla_cfg_reg_t;

  // Which off-diagonal neighbors of a cell lie inside the grid.
  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
  } vcla_nbr_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    vcla_nbr_t       nbr;
    logic            grid_end;
  } vcla_tag_t;

  // Sums of the cell coefficient with each neighbor (Q8.9 averages).
  typedef struct packed {
    logic [SUM_W-1:0] l;
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] u;
    logic [SUM_W-1:0] d;
  } vcla_sums_t;

  typedef struct packed {
    vcla_tag_t  tag;
    vcla_sums_t sums;
  } vcla_job_t;

endpackage

[rtl/vcla_cell.sv]
// ----------------------------------------------------------------------------
// vcla_cell
// One storage cell of a line buffer chain: loads the new sample when it is
// the tail of the chain, otherwise takes the word of its upstream neighbor.
// ----------------------------------------------------------------------------
module vcla_cell #(
  parameter int WIDTH = vcla_pkg::SAMPLE_W
) (
  input  logic             clk,
  input  logic             shift,
  input  logic             inject,
  input  logic [WIDTH-1:0] din,
  input  logic [WIDTH-1:0] nbr,
  output logic [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= inject ? din : nbr;
    end
  end

endmodule

[rtl/vcla_line.sv]
// ----------------------------------------------------------------------------
// vcla_line
// Programmable-length delay line built from a chain of cells. New samples
// enter at the cell selected by tail and move one cell toward the head per
// shift, so the head shows the sample from tail + 1 shifts ago.
// ----------------------------------------------------------------------------
module vcla_line #(
  parameter  int DEPTH = vcla_pkg::MAX_COLS_DEF + 1,
  parameter  int WIDTH = vcla_pkg::SAMPLE_W,
  localparam int IW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [IW-1:0]    tail,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] cq [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WIDTH-1:0] nbr;

    if (k == DEPTH - 1) begin : g_end
      assign nbr = din;
    end else begin : g_mid
      assign nbr = cq[k+1];
    end

    vcla_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk    (clk),
      .shift  (shift),
      .inject (tail == IW'(k)),
      .din    (din),
      .nbr    (nbr),
      .q      (cq[k])
    );
  end

  assign dout = cq[0];

endmodule

[rtl/vcla_engine.sv]
// ----------------------------------------------------------------------------
// vcla_engine
// Weight pipeline and entry sequencer: multiplies the four coefficient sums by
// 1/h^2, forms the diagonal, and issues one matrix entry per cycle into the
// output register while that register is free.
// ----------------------------------------------------------------------------
module vcla_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [vcla_pkg::INV_W-1:0]      inv_h2,
  input  logic [vcla_pkg::ID_W-1:0]       cols_id,
  input  logic                            job_valid,
  output logic                            job_ready,
  input  vcla_pkg::vcla_job_t             job,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [vcla_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                            m_tlast,
  output logic [vcla_pkg::M_USER_W-1:0]   m_tuser
);

  import vcla_pkg::*;

  // Multiply stage
  logic              s1_valid;
  logic              s1_ready;
  vcla_tag_t         s1_tag;
  logic [WT_W-1:0]   s1_wl, s1_wr, s1_wu, s1_wd;

  // Pair-sum stage
  logic              s2_valid;
  logic              s2_ready;
  vcla_tag_t         s2_tag;
  logic [WT_W-1:0]   s2_wl, s2_wr, s2_wu, s2_wd;
  logic [PAIR_W-1:0] s2_p0, s2_p1;

  // Entry sequencer
  logic              e_valid;
  logic              e_ready;
  vcla_tag_t         e_tag;
  vcla_nbr_t         e_pend;
  vcla_nbr_t         pend_next;
  logic [WT_W-1:0]   e_wl, e_wr, e_wu, e_wd;
  logic [DIAG_W-1:0] e_diag;
  logic              e_last;
  logic              out_free;
  logic              emit;

  logic [ID_W-1:0]   sel_col;
  logic [VAL_W-1:0]  sel_val;

  assign s1_ready  = !s1_valid || s2_ready;
  assign s2_ready  = !s2_valid || e_ready;
  assign job_ready = s1_ready;

  assign out_free = !m_tvalid || m_tready;
  assign e_last   = (e_pend == '0);
  assign emit     = e_valid && out_free;
  assign e_ready  = !e_valid || (out_free && e_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      e_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= job_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (e_ready) begin
        e_valid <= s2_valid;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && job_valid) begin
      s1_tag <= job.tag;
      s1_wl  <= WT_W'(job.sums.l) * WT_W'(inv_h2);
      s1_wr  <= WT_W'(job.sums.r) * WT_W'(inv_h2);
      s1_wu  <= WT_W'(job.sums.u) * WT_W'(inv_h2);
      s1_wd  <= WT_W'(job.sums.d) * WT_W'(inv_h2);
    end
    if (s2_ready && s1_valid) begin
      s2_tag <= s1_tag;
      s2_wl  <= s1_wl;
      s2_wr  <= s1_wr;
      s2_wu  <= s1_wu;
      s2_wd  <= s1_wd;
      s2_p0  <= PAIR_W'(s1_wl) + PAIR_W'(s1_wr);
      s2_p1  <= PAIR_W'(s1_wu) + PAIR_W'(s1_wd);
    end
    if (e_ready && s2_valid) begin
      e_tag  <= s2_tag;
      e_pend <= s2_tag.nbr;
      e_wl   <= s2_wl;
      e_wr   <= s2_wr;
      e_wu   <= s2_wu;
      e_wd   <= s2_wd;
      e_diag <= DIAG_W'(s2_p0) + DIAG_W'(s2_p1);
    end else if (emit) begin
      e_pend <= pend_next;
    end
  end

  // Entries leave in the order left, right, up, down, then the diagonal.
  always_comb begin
    pend_next = e_pend;
    sel_col   = e_tag.id;
    sel_val   = VAL_W'(e_diag);
    if (e_pend.left) begin
      pend_next.left = 1'b0;
      sel_col        = e_tag.id - ID_W'(1);
      sel_val        = VAL_W'(0) - VAL_W'(e_wl);
    end else if (e_pend.right) begin
      pend_next.right = 1'b0;
      sel_col         = e_tag.id + ID_W'(1);
      sel_val         = VAL_W'(0) - VAL_W'(e_wr);
    end else if (e_pend.up) begin
      pend_next.up = 1'b0;
      sel_col      = e_tag.id - cols_id;
      sel_val      = VAL_W'(0) - VAL_W'(e_wu);
    end else if (e_pend.down) begin
      pend_next.down = 1'b0;
      sel_col        = e_tag.id + cols_id;
      sel_val        = VAL_W'(0) - VAL_W'(e_wd);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata    <= {sel_val, sel_col, e_tag.id};
      m_tlast    <= e_last;
      m_tuser[0] <= e_last && e_tag.grid_end;
    end
  end

endmodule

[rtl/variable_coeff_laplacian_assembly.sv]
// ----------------------------------------------------------------------------
// variable_coeff_laplacian_assembly
// Streams a padded Q8.8 coefficient grid and emits the five-point Laplacian
// matrix rows of its interior cells as Q30.17 (row, column, value) words.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ side takes one padded-grid sample per word in raster order. The
//   m_ side delivers matrix entries: left, right, up, down neighbors that lie
//   inside the grid, then the diagonal, which carries tlast; tuser marks the
//   diagonal of the final cell of the grid. Border samples produce no word.
//   The cfg port sets the interior size and 1/h^2; write it only while idle
//   (not enforced). A size write restarts the grid at its first sample.
// Timing:
//   The matrix row of a cell is ready once the sample below it is accepted.
//   Its first word passes the job register, the multiply, pair-sum and entry
//   sequencer stages and the single output register, which then issues one
//   word per cycle while m_tready is high. A cell holds the entry sequencer
//   until the last of its words (1 to 5) has been issued.
// Reset and stall:
//   Synchronous reset empties the pipeline and returns to the first sample
//   with 64 x 64 cells and 1/h^2 = 4225.0. When m_tready is low the output
//   word holds and the four pipeline stages fill before s_tready drops.
// ----------------------------------------------------------------------------
module variable_coeff_laplacian_assembly #(
  parameter int MAX_COLS = vcla_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = vcla_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vcla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vcla_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vcla_pkg::S_DATA_W-1:0]    s_tdata,   // [15:0] coeff
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vcla_pkg::M_DATA_W-1:0]    m_tdata,   // [11:0] row_index,
                                                      // [23:12] col_index,
                                                      // [71:24] value
  output logic                             m_tlast,   // last_of_run
  output logic [vcla_pkg::M_USER_W-1:0]    m_tuser    // [0] last_of_grid
);

  import vcla_pkg::*;

  localparam int XW  = $clog2(MAX_COLS + 2);
  localparam int YW  = $clog2(MAX_ROWS + 2);
  localparam int AD  = MAX_COLS + 1;
  localparam int BD  = MAX_COLS + 2;
  localparam int AIW = $clog2(AD);
  localparam int BIW = $clog2(BD);

  logic [DIM_W-1:0]    cols_raw;
  logic [DIM_W-1:0]    rows_raw;
  logic [INV_W-1:0]    inv_h2;
  logic [XW-1:0]       cols;
  logic [YW-1:0]       rows;

  logic [XW-1:0]       px;
  logic [YW-1:0]       py;
  logic [ID_W-1:0]     cell_id;

  logic                accept;
  logic                interior;
  logic                last_col;
  logic                last_row;

  logic [SAMPLE_W-1:0] tap_r;
  logic [SAMPLE_W-1:0] tap_c;
  logic [SAMPLE_W-1:0] tap_l;
  logic [SAMPLE_W-1:0] tap_u;
  logic [SAMPLE_W-1:0] tap_d;

  logic                j0_valid;
  logic                j0_ready;
  vcla_job_t           j0;
  vcla_job_t           job_next;

  // Out-of-range sizes saturate to 1..MAX.
  always_comb begin
    if (cols_raw == '0) begin
      cols = XW'(1);
    end else if (int'(cols_raw) > MAX_COLS) begin
      cols = XW'(MAX_COLS);
    end else begin
      cols = XW'(cols_raw);
    end
    if (rows_raw == '0) begin
      rows = YW'(1);
    end else if (int'(rows_raw) > MAX_ROWS) begin
      rows = YW'(MAX_ROWS);
    end else begin
      rows = YW'(rows_raw);
    end
  end

  assign s_tready = !j0_valid || j0_ready;
  assign accept   = s_tvalid && s_tready;
  assign last_col = (px == cols + XW'(1));
  assign last_row = (py == rows + YW'(1));
  assign interior = (py >= YW'(2)) && (px >= XW'(1)) && (px <= cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_raw <= CFG_COLS_RST;
      rows_raw <= CFG_ROWS_RST;
      inv_h2   <= CFG_INV_RST;
      px       <= '0;
      py       <= '0;
      cell_id  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS: begin
          cols_raw <= cfg_data[DIM_W-1:0];
          px       <= '0;
          py       <= '0;
          cell_id  <= '0;
        end
        REG_ROWS: begin
          rows_raw <= cfg_data[DIM_W-1:0];
          px       <= '0;
          py       <= '0;
          cell_id  <= '0;
        end
        REG_INV_H2: begin
          inv_h2 <= cfg_data[INV_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (interior) begin
        cell_id <= cell_id + ID_W'(1);
      end
      if (last_col) begin
        px <= '0;
        if (last_row) begin
          py      <= '0;
          cell_id <= '0;
        end else begin
          py <= py + YW'(1);
        end
      end else begin
        px <= px + XW'(1);
      end
    end
  end

  // The first line delays by one padded row less one sample, giving the
  // upper-right tap; two registers then give the cell and its left tap, and
  // the second line delays the cell tap by a full row for the up tap.
  vcla_line #(
    .DEPTH (AD),
    .WIDTH (SAMPLE_W)
  ) u_line_a (
    .clk   (clk),
    .shift (accept),
    .tail  (AIW'(cols)),
    .din   (s_tdata),
    .dout  (tap_r)
  );

  vcla_line #(
    .DEPTH (BD),
    .WIDTH (SAMPLE_W)
  ) u_line_b (
    .clk   (clk),
    .shift (accept),
    .tail  (BIW'(cols + XW'(1))),
    .din   (tap_c),
    .dout  (tap_u)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      tap_c <= tap_r;
      tap_l <= tap_c;
    end
  end

  assign tap_d = s_tdata;

  always_comb begin
    job_next.tag.id        = cell_id;
    job_next.tag.nbr.left  = (px > XW'(1));
    job_next.tag.nbr.right = (px < cols);
    job_next.tag.nbr.up    = (py > YW'(2));
    job_next.tag.nbr.down  = (py < rows + YW'(1));
    job_next.tag.grid_end  = (px == cols) && last_row;
    job_next.sums.l        = SUM_W'(tap_l) + SUM_W'(tap_c);
    job_next.sums.r        = SUM_W'(tap_r) + SUM_W'(tap_c);
    job_next.sums.u        = SUM_W'(tap_u) + SUM_W'(tap_c);
    job_next.sums.d        = SUM_W'(tap_d) + SUM_W'(tap_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j0_valid <= 1'b0;
    end else if (s_tready) begin
      j0_valid <= accept && interior;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && interior) begin
      j0 <= job_next;
    end
  end

  vcla_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .inv_h2    (inv_h2),
    .cols_id   (ID_W'(cols)),
    .job_valid (j0_valid),
    .job_ready (j0_ready),
    .job       (j0),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

[rtl/vcla_checker.sv]
// ----------------------------------------------------------------------------
// vcla_checker
// Port-level checks on the matrix entry stream of the Laplacian assembly.
// ----------------------------------------------------------------------------
`include "variable_coeff_laplacian_assembly_defines.svh"

module vcla_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [vcla_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                           m_tlast,
  input logic [vcla_pkg::M_USER_W-1:0]  m_tuser
);

  // A stalled word must stay on the bus unchanged.
  `VCLA_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled word changed")

  // The end of the grid is always a diagonal entry.
  `VCLA_ASSERT_SAME(a_grid_end, clk, rst, m_tvalid && m_tuser[0], m_tlast, "grid end off the diagonal")

  // The diagonal entry sits in its own row.
  `VCLA_ASSERT_SAME(a_diag_col, clk, rst, m_tvalid && m_tlast, m_tdata[23:12] == m_tdata[11:0], "diagonal column differs from row")

  // Off-diagonal entries are minus a weight, never positive.
  `VCLA_ASSERT_SAME(a_off_sign, clk, rst, m_tvalid && !m_tlast, m_tdata[71] || (m_tdata[71:24] == 48'd0), "positive off-diagonal entry")

endmodule

bind variable_coeff_laplacian_assembly vcla_checker u_vcla_checker (.*);

[dv/variable_coeff_laplacian_assembly_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_coeff_laplacian_assembly_tb
// Streams padded coefficient grids of many sizes through the Laplacian
// assembly block under random source and sink stalls. A cycle-free predictor
// builds the expected matrix words of every cell; each output word is then
// compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module variable_coeff_laplacian_assembly_tb;
  import vcla_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LINE_DEPTH = MAX_COLS_DEF + 2;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 80;

  typedef enum int {PHASE_RANDOM, PHASE_SINGLE, PHASE_SQUEEZE} phase_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]  row;
    logic [ID_W-1:0]  col;
    logic [VAL_W-1:0] value;
    logic             run_end;
    logic             grid_end;
  } matrix_entry_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tlast;
  logic [M_USER_W-1:0]   m_tuser;

  variable_coeff_laplacian_assembly DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // Predictor state: two line buffers, scan position and register copies.
  logic [S_DATA_W-1:0] line_above [LINE_DEPTH];
  logic [S_DATA_W-1:0] line_two_above [LINE_DEPTH];
  logic [S_DATA_W-1:0] delayed_coeff = '0;
  int unsigned         scan_x = 0;
  int unsigned         scan_y = 0;
  logic [DIM_W-1:0]    cols_setting = CFG_COLS_RST;
  logic [DIM_W-1:0]    rows_setting = CFG_ROWS_RST;
  logic [INV_W-1:0]    inv_h2_setting = CFG_INV_RST;

  matrix_entry_t       expected_entries[$];
  logic [S_DATA_W-1:0] coeff_backlog[$];

  int unsigned src_idle_max = 0;
  int unsigned sink_idle_max = 0;
  int unsigned src_wait = 0;
  int unsigned sink_wait = 0;
  int unsigned sink_next = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned samples_queued = 0;
  int unsigned samples_accepted = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned phases_run = 0;

  always #1 clk = ~clk;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic logic [VAL_W-1:0] edge_weight(logic [S_DATA_W-1:0] a,
                                                   logic [S_DATA_W-1:0] b);
    logic [VAL_W-1:0] pair_sum;
    pair_sum = a;
    pair_sum = pair_sum + b;
    return pair_sum * inv_h2_setting;
  endfunction

  function automatic void push_entry(logic [ID_W-1:0] row, logic [ID_W-1:0] col,
                                     logic [VAL_W-1:0] value, logic run_end,
                                     logic grid_end);
    matrix_entry_t e;
    e.row = row;
    e.col = col;
    e.value = value;
    e.run_end = run_end;
    e.grid_end = grid_end;
    expected_entries.push_back(e);
  endfunction

  // Advances the predictor by one accepted coefficient and queues the
  // matrix row of the cell above it, if that cell is interior.
  function automatic void assemble_cell(logic [S_DATA_W-1:0] coeff_in);
    int unsigned cols, rows, span_x, span_y, px, py, x, y;
    logic [S_DATA_W-1:0] center;
    logic [VAL_W-1:0] wl, wr, wu, wd;
    logic [ID_W-1:0] id;
    cols = clamp_dim(cols_setting, MAX_COLS_DEF);
    rows = clamp_dim(rows_setting, MAX_ROWS_DEF);
    span_x = cols + 2;
    span_y = rows + 2;
    px = (scan_x >= span_x) ? 0 : scan_x;
    py = (scan_y >= span_y) ? 0 : scan_y;
    if (py >= 2 && px >= 1 && px <= cols) begin
      x = px - 1;
      y = py - 2;
      center = line_above[px];
      wl = edge_weight(line_above[px - 1], center);
      wr = edge_weight(line_above[px + 1], center);
      wu = edge_weight(line_two_above[px], center);
      wd = edge_weight(coeff_in, center);
      id = ID_W'(x + y * cols);
      if (x > 0) push_entry(id, id - 1'b1, -wl, 1'b0, 1'b0);
      if (x < cols - 1) push_entry(id, id + 1'b1, -wr, 1'b0, 1'b0);
      if (y > 0) push_entry(id, id - ID_W'(cols), -wu, 1'b0, 1'b0);
      if (y < rows - 1) push_entry(id, id + ID_W'(cols), -wd, 1'b0, 1'b0);
      push_entry(id, id, wl + wr + wu + wd, 1'b1, (x == cols - 1) && (y == rows - 1));
    end
    // The buffer entry of a column lands one sample late, so the left tap
    // above still holds the previous row when it is read.
    if (px >= 1) begin
      line_two_above[px - 1] = line_above[px - 1];
      line_above[px - 1] = delayed_coeff;
    end
    if (px == span_x - 1) begin
      line_two_above[px] = line_above[px];
      line_above[px] = coeff_in;
    end
    delayed_coeff = coeff_in;
    px++;
    if (px >= span_x) begin
      px = 0;
      py++;
      if (py >= span_y) py = 0;
    end
    scan_x = px;
    scan_y = py;
  endfunction

  function automatic void compare_field(string name, logic [VAL_W-1:0] expected_v,
                                        logic [VAL_W-1:0] actual_v);
    if (actual_v !== expected_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of word %0d: expected %h, got %h",
                 name, words_checked, expected_v, actual_v);
    end
  endfunction

  function automatic void check_word();
    matrix_entry_t e;
    words_checked++;
    if (expected_entries.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d arrived with nothing expected: tdata %h", words_checked, m_tdata);
      return;
    end
    e = expected_entries.pop_front();
    compare_field("row_index", e.row, m_tdata[ID_W-1:0]);
    compare_field("col_index", e.col, m_tdata[2*ID_W-1:ID_W]);
    compare_field("value", e.value, m_tdata[M_DATA_W-1:2*ID_W]);
    compare_field("last_of_run", e.run_end, m_tlast);
    compare_field("last_of_grid", e.grid_end, m_tuser[0]);
  endfunction

  // Source side: one coefficient word at a time from the backlog.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        assemble_cell(s_tdata);
        samples_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait != 0) begin
          s_tvalid <= 1'b0;
          src_wait <= src_wait - 1;
        end else if (coeff_backlog.size() != 0) begin
          s_tdata <= coeff_backlog.pop_front();
          s_tvalid <= 1'b1;
          src_wait <= $urandom_range(0, src_idle_max);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: checks each accepted word, then idles for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else begin
      sink_next = sink_wait;
      if (m_tvalid && m_tready) begin
        check_word();
        sink_next = $urandom_range(0, sink_idle_max);
      end else if (sink_next != 0) begin
        sink_next = sink_next - 1;
      end
      sink_wait <= sink_next;
      m_tready <= (sink_next == 0) && (hold_left == 0);
    end
  end

  // Long sink hold-off, counted here so the source keeps offering words.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      holds_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= reg_index;
    cfg_data <= data;
    case (reg_index)
      REG_COLS: begin
        cols_setting = data[DIM_W-1:0];
        scan_x = 0;
        scan_y = 0;
      end
      REG_ROWS: begin
        rows_setting = data[DIM_W-1:0];
        scan_x = 0;
        scan_y = 0;
      end
      REG_INV_H2: inv_h2_setting = data[INV_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (coeff_backlog.size() != 0 || s_tvalid || expected_entries.size() != 0);
    // Border words make no output but may still be in flight.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [S_DATA_W-1:0] draw_coeff();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      default: return S_DATA_W'($urandom());
    endcase
  endfunction

  function automatic void queue_samples(int unsigned count);
    repeat (count) coeff_backlog.push_back(draw_coeff());
    samples_queued += count;
  endfunction

  // Size fields carry random upper bits, which the block must ignore.
  function automatic logic [CFG_DATA_W-1:0] dim_word(logic [DIM_W-1:0] raw);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom());
    data[DIM_W-1:0] = raw;
    return data;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 3) == 0) return DIM_W'($urandom_range(1, 8));
    return DIM_W'($urandom_range(1, 3));
  endfunction

  task automatic random_phase(logic [DIM_W-1:0] cols_raw, logic [DIM_W-1:0] rows_raw,
                              phase_kind_t kind);
    int unsigned span_x, total, base, part;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_COLS, dim_word(cols_raw));
      write_reg(REG_ROWS, dim_word(rows_raw));
    end else begin
      write_reg(REG_ROWS, dim_word(rows_raw));
      write_reg(REG_COLS, dim_word(cols_raw));
    end
    case ($urandom_range(0, 3))
      0: write_reg(REG_INV_H2, '0);
      1: write_reg(REG_INV_H2, '1);
      2: write_reg(REG_INV_H2, CFG_DATA_W'($urandom()));
      default: ;
    endcase
    if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    span_x = clamp_dim(cols_raw, MAX_COLS_DEF) + 2;
    total = span_x * (clamp_dim(rows_raw, MAX_ROWS_DEF) + 2);
    src_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
    sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
    base = samples_accepted;
    if (kind != PHASE_RANDOM) begin
      if (kind == PHASE_SQUEEZE) src_idle_max = 0;
      queue_samples(total);
      if (kind == PHASE_SQUEEZE) begin
        // Start the hold once matrix words are flowing, so the pipeline fills.
        wait (samples_accepted >= base + 2 * span_x + 2);
        hold_requests++;
      end
    end else begin
      case ($urandom_range(0, 9))
        6, 7: queue_samples(2 * total);
        8: begin
          part = total / 2;
          queue_samples(part);
          wait_drained();
          queue_samples(total - part);
        end
        // Cut short; the size write of the next phase restarts the grid.
        9: queue_samples($urandom_range(1, total - 1));
        default: queue_samples(total);
      endcase
    end
    wait_drained();
    phases_run++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Smallest grid at the reset 1/h^2, with a column count of zero that
    // saturates to one and a write to an index past the register list.
    write_reg(REG_UNUSED, 24'hABCDEF);
    write_reg(REG_COLS, '0);
    write_reg(REG_ROWS, 24'd1);
    for (int i = 0; i < 9; i++) coeff_backlog.push_back(S_DATA_W'(i * 16'h1111));
    samples_queued += 9;
    wait_drained();
    phases_run++;

    // 2x2 grid with the largest 1/h^2 and full-scale coefficients.
    write_reg(REG_COLS, 24'd2);
    write_reg(REG_ROWS, 24'd2);
    write_reg(REG_INV_H2, '1);
    for (int i = 0; i < 16; i++) coeff_backlog.push_back((i % 3 == 0) ? 16'h0000 : 16'hFFFF);
    samples_queued += 16;
    wait_drained();
    phases_run++;

    while (samples_queued < 30) random_phase(pick_dim(), pick_dim(), PHASE_RANDOM);
    random_phase(7'd127, 7'd0, PHASE_SQUEEZE);
    random_phase(7'd1, 7'd12, PHASE_SINGLE);

    $display("covered %0d grid settings and %0d coefficient words, from a 1x1 grid up to",
             phases_run, samples_accepted);
    $display("a saturated 64-column width; %0d matrix words checked, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/vcla_pkg.sv
rtl/vcla_cell.sv
rtl/vcla_line.sv
rtl/vcla_engine.sv
rtl/variable_coeff_laplacian_assembly.sv
rtl/vcla_checker.sv
dv/variable_coeff_laplacian_assembly_tb.sv
